// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  localparam int DATA_W  = 8;
  localparam int OPRIO_W = 8;
  localparam int FILL_W  = 4;

  typedef struct packed {
    logic load;  // capture the input transaction
    logic exec;  // apply the operation to the cell chain
  } dp_cmd_t;

endpackage

// File: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accepts a transaction, runs it through the datapath and holds
// the result valid until the sink takes it.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output spq_pkg::dp_cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (accept) state_nxt = spq_pkg::ST_EXEC;
      end
      spq_pkg::ST_EXEC: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        cmd.load  = in_tvalid && (!out_valid_r || out_tready);
      end
      spq_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_tready) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !out_valid_r)
    else $error("result register busy during execute");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (cmd.exec && !in_tready))
    else $error("accepted transaction not executed");

  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed transaction produced no result");

  a_load_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load == accept)
    else $error("load strobe out of step with accept");

endmodule

// File: design/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Sorted cell chain: every cell compares its priority with the incoming one
// and takes the new item, its neighbor, or keeps its value.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int DEPTH      = 8,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::dp_cmd_t              cmd,
  input  logic                          func,
  input  logic [spq_pkg::DATA_W-1:0]    item_data,
  input  logic [spq_pkg::OPRIO_W-1:0]   item_priority,
  output logic [spq_pkg::DATA_W-1:0]    out_data,
  output logic [spq_pkg::OPRIO_W-1:0]   out_priority,
  output logic [1:0]                    status,
  output logic [spq_pkg::FILL_W-1:0]    fill_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [PRIO_WIDTH-1:0]      prio_r [DEPTH];
  logic [PRIO_WIDTH-1:0]      prio_nxt [DEPTH];
  logic [spq_pkg::DATA_W-1:0] data_r [DEPTH];
  logic [spq_pkg::DATA_W-1:0] data_nxt [DEPTH];
  logic [CW-1:0]              count_r, count_nxt;

  logic                       op_r;
  logic [spq_pkg::DATA_W-1:0] din_r;
  logic [PRIO_WIDTH-1:0]      pin_r;

  logic [spq_pkg::DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [PRIO_WIDTH-1:0]       out_prio_r, out_prio_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic [spq_pkg::FILL_W-1:0]  fill_r, fill_nxt;

  logic [DEPTH-1:0] gt;
  logic             full, empty;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CW'(i) < count_r) && (prio_r[i] > pin_r);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      data_nxt[i] = data_r[i];
    end
    count_nxt    = count_r;
    out_data_nxt = out_data_r;
    out_prio_nxt = out_prio_r;
    status_nxt   = status_r;
    fill_nxt     = fill_r;
    if (cmd.exec) begin
      out_data_nxt = '0;
      out_prio_nxt = '0;
      if (op_r == spq_pkg::FUNC_ENQ) begin
        if (full) begin
          status_nxt = spq_pkg::STATUS_OVERFLOW;
          fill_nxt   = spq_pkg::FILL_W'(count_r);
        end else begin
          if (gt[0] || empty) begin
            prio_nxt[0] = pin_r;
            data_nxt[0] = din_r;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (gt[i-1]) begin
              prio_nxt[i] = prio_r[i-1];
              data_nxt[i] = data_r[i-1];
            end else if (gt[i] || (CW'(i) == count_r)) begin
              prio_nxt[i] = pin_r;
              data_nxt[i] = din_r;
            end
          end
          count_nxt  = count_r + CW'(1);
          status_nxt = spq_pkg::STATUS_OK;
          fill_nxt   = spq_pkg::FILL_W'(count_r + CW'(1));
        end
      end else begin
        if (empty) begin
          status_nxt = spq_pkg::STATUS_UNDERFLOW;
          fill_nxt   = '0;
        end else begin
          out_data_nxt = data_r[0];
          out_prio_nxt = prio_r[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            prio_nxt[i] = prio_r[i+1];
            data_nxt[i] = data_r[i+1];
          end
          count_nxt  = count_r - CW'(1);
          status_nxt = spq_pkg::STATUS_OK;
          fill_nxt   = spq_pkg::FILL_W'(count_r - CW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      prio_r[i] <= prio_nxt[i];
      data_r[i] <= data_nxt[i];
    end
    out_data_r <= out_data_nxt;
    out_prio_r <= out_prio_nxt;
    status_r   <= status_nxt;
    fill_r     <= fill_nxt;
    if (cmd.load) begin
      op_r  <= func;
      din_r <= item_data;
      pin_r <= PRIO_WIDTH'(item_priority);
    end
  end

  assign out_data     = out_data_r;
  assign out_priority = spq_pkg::OPRIO_W'(out_prio_r);
  assign status       = status_r;
  assign fill_count   = fill_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == spq_pkg::FUNC_ENQ && full) |=> $stable(count_r))
    else $error("count changed on overflow");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (prio_r[0] <= prio_r[1]))
    else $error("head entries out of order");

endmodule

// File: design/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue held as a sorted cell chain, ascending priority,
// first-in first-out among equal priorities.
//
//   channel  dir  ports                         contents
//   in_      in   tvalid tready tdata tuser     enqueue / dequeue request
//   out_     out  tvalid tready tdata tuser     one result per request
//
// Each transaction is first registered, then the cell chain inserts or
// shifts and loads the result register.
// A new transaction is taken while the previous result drains from the
// result register in the same cycle.
// Reset clears the entry count and the result valid; no clearing pass.
// A stalled out_tready holds the result and blocks further input.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int DEPTH      = 8,
  parameter int PRIO_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // item_data[7:0], item_priority[15:8]
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_data[7:0], out_priority[15:8],
                                  // fill_count[19:16], zero[23:20]
  output logic [1:0]  out_tuser   // status[1:0]
);

  spq_pkg::dp_cmd_t cmd;

  logic [spq_pkg::DATA_W-1:0]  out_data;
  logic [spq_pkg::OPRIO_W-1:0] out_priority;
  logic [1:0]                  status;
  logic [spq_pkg::FILL_W-1:0]  fill_count;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dp #(
    .DEPTH      (DEPTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .func          (in_tuser[0]),
    .item_data     (in_tdata[7:0]),
    .item_priority (in_tdata[15:8]),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .status        (status),
    .fill_count    (fill_count)
  );

  assign out_tdata = {4'b0000, fill_count, out_priority, out_data};
  assign out_tuser = status;

endmodule
